// ===== rtl/dlht_pkg.sv =====
// Shared constants, codes and control types for the d-left hash table.
`timescale 1ns / 1ps
package dlht_pkg;

  localparam int SUBTABLE_COUNT = 4;
  localparam int BUCKETS        = 16;
  localparam int FACE_COUNT     = 4;

  localparam int SLOT_TOTAL = SUBTABLE_COUNT * BUCKETS;
  localparam int SUB_W      = (SUBTABLE_COUNT > 1) ? $clog2(SUBTABLE_COUNT) : 1;
  localparam int BKT_W      = $clog2(BUCKETS);
  localparam int ADDR_W     = $clog2(SLOT_TOTAL);
  localparam bit BKT_POW2   = (BUCKETS == (1 << BKT_W));

  localparam int KEY_W    = 32;
  localparam int EXP_W    = 32;
  localparam int FACE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int HSUB_W   = 2;
  localparam int HBKT_W   = 4;

  localparam int WORD_W    = FACE_COUNT + EXP_W + KEY_W;
  localparam int MOD_STEPS = 3;
  localparam int MOD_CNT_W = 2;

  // key mod BUCKETS by reciprocal multiply: q = (key * RECIP_M) >> RECIP_SH
  localparam int          RECIP_SH   = KEY_W + BKT_W;
  localparam int          RECIP_LO_W = 17;
  localparam int          RECIP_HI_W = 16;
  localparam int          PROD_W     = KEY_W + RECIP_LO_W + RECIP_HI_W;
  localparam logic [63:0] RECIP_M    = ((64'd1 << RECIP_SH) + 64'(BUCKETS) - 64'd1)
                                       / 64'(BUCKETS);
  localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP_M[RECIP_LO_W-1:0];
  localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP_M[RECIP_LO_W +: RECIP_HI_W];

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_FACE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic ins_step;
    logic srch_step;
    logic res_load;
  } dlht_cmd_t;

  typedef struct packed {
    logic is_search;
    logic mod_last;
    logic ins_done;
    logic srch_done;
  } dlht_sts_t;

endpackage

// ===== rtl/dlht_if.sv =====
// Request and result channel interfaces of the d-left hash table.
`timescale 1ns / 1ps
interface dlht_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [dlht_pkg::KEY_W-1:0]   key_fingerprint;
  logic [dlht_pkg::EXP_W-1:0]   expire_time;
  logic [dlht_pkg::FACE_W-1:0]  face_number;

  modport source (output valid, req_type, key_fingerprint, expire_time, face_number,
                  input ready);
  modport sink (input valid, req_type, key_fingerprint, expire_time, face_number,
                output ready);
endinterface

interface dlht_res_if;
  logic                          valid;
  logic                          ready;
  logic [dlht_pkg::STATUS_W-1:0] status;
  logic [dlht_pkg::HSUB_W-1:0]   hit_subtable;
  logic [dlht_pkg::HBKT_W-1:0]   hit_bucket;

  modport source (output valid, status, hit_subtable, hit_bucket, input ready);
  modport sink (input valid, status, hit_subtable, hit_bucket, output ready);
endinterface

// ===== rtl/dlht_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module dlht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/dlht_ctrl.sv =====
// Control state machine: sequences bucket reduction, probes and result hand-off.
`timescale 1ns / 1ps
module dlht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_type,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dlht_pkg::dlht_sts_t sts,
  output dlht_pkg::dlht_cmd_t cmd
);
  import dlht_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;
  localparam logic [1:0] S_SRCH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!BKT_POW2) begin
            state_nxt = S_MOD;
          end else if (in_type == REQ_SEARCH) begin
            state_nxt = S_SRCH;
          end else begin
            state_nxt = S_INS;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = sts.is_search ? S_SRCH : S_INS;
        end
      end
      S_INS: begin
        if (out_free) begin
          cmd.ins_step = 1'b1;
          if (sts.ins_done) begin
            cmd.res_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_SRCH: begin
        if (out_free) begin
          cmd.srch_step = 1'b1;
          if (sts.srch_done) begin
            cmd.res_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ===== rtl/dlht_dp.sv =====
// Datapath: request registers, probe counters, occupancy bits, slot RAM, result register.
`timescale 1ns / 1ps
module dlht_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dlht_pkg::dlht_cmd_t             cmd,
  output dlht_pkg::dlht_sts_t             sts,
  input  logic                            in_type,
  input  logic [dlht_pkg::KEY_W-1:0]      in_key,
  input  logic [dlht_pkg::EXP_W-1:0]      in_exp,
  input  logic [dlht_pkg::FACE_W-1:0]     in_face,
  output logic [dlht_pkg::STATUS_W-1:0]   out_status,
  output logic [dlht_pkg::HSUB_W-1:0]     out_sub,
  output logic [dlht_pkg::HBKT_W-1:0]     out_bkt
);
  import dlht_pkg::*;

  logic                  type_r;
  logic [KEY_W-1:0]      key_r;
  logic [EXP_W-1:0]      exp_r;
  logic [FACE_W-1:0]     face_r;
  logic [SUB_W-1:0]      sub_r;
  logic [BKT_W-1:0]      bkt_r, bkt_nxt;
  logic [KEY_W-1:0]      kcnt_r, kcnt_inc;
  logic [SLOT_TOTAL-1:0] occ_r;
  logic                  cmp_pend_r, cmp_occ_r, cmp_last_r;
  logic [SUB_W-1:0]      cmp_sub_r;
  logic [BKT_W-1:0]      cmp_bkt_r;
  logic [STATUS_W-1:0]   res_status_r, res_status;
  logic [HSUB_W-1:0]     res_sub_r, res_sub;
  logic [HBKT_W-1:0]     res_bkt_r, res_bkt;

  logic [ADDR_W-1:0]     slot_addr;
  logic                  sub_last, face_ok, slot_free, ins_write, advance, hit;
  logic [BKT_W-1:0]      bkt_inc, bkt_load, bkt_mod;
  logic                  mod_last;
  logic [FACE_COUNT-1:0] face_bits;
  logic [WORD_W-1:0]     rdata;

  assign slot_addr = ADDR_W'(sub_r) * ADDR_W'(BUCKETS) + ADDR_W'(bkt_r);
  assign sub_last  = (sub_r == SUB_W'(SUBTABLE_COUNT - 1));
  assign face_ok   = (face_r < FACE_W'(FACE_COUNT));
  assign slot_free = !occ_r[slot_addr];
  assign ins_write = cmd.ins_step && face_ok && slot_free;
  assign advance   = (cmd.ins_step || cmd.srch_step) && !sub_last;
  assign face_bits = FACE_COUNT'(1) << face_r;
  assign hit       = cmp_pend_r && cmp_occ_r && (rdata[KEY_W-1:0] == key_r);

  assign kcnt_inc = kcnt_r + KEY_W'(1);
  // bucket of key+s+1: wraps at BUCKETS, and restarts at 0 when the 32-bit sum wraps
  assign bkt_inc  = ((kcnt_inc == '0) || (bkt_r == BKT_W'(BUCKETS - 1))) ? '0
                  : bkt_r + BKT_W'(1);

  generate
    if (BKT_POW2) begin : g_pow2
      assign bkt_load = in_key[BKT_W-1:0];
      assign bkt_mod  = bkt_r;
      assign mod_last = 1'b1;
    end else begin : g_mod
      // key mod BUCKETS: split reciprocal multiply, quotient, then low bits of key - q*B
      logic [KEY_W+RECIP_LO_W-1:0] plo_r;
      logic [KEY_W+RECIP_HI_W-1:0] phi_r;
      logic [BKT_W-1:0]            qlo_r;
      logic [MOD_CNT_W-1:0]        cnt_r;
      logic [PROD_W-1:0]           prod;
      logic [2*BKT_W-1:0]          qb;

      assign prod     = (PROD_W'(phi_r) << RECIP_LO_W) + PROD_W'(plo_r);
      assign qb       = (2*BKT_W)'(qlo_r) * (2*BKT_W)'(BUCKETS);
      assign bkt_load = '0;
      assign bkt_mod  = key_r[BKT_W-1:0] - qb[BKT_W-1:0];
      assign mod_last = (cnt_r == '0);

      always_ff @(posedge clk) begin
        if (cmd.load) begin
          cnt_r <= MOD_CNT_W'(MOD_STEPS - 1);
        end else if (cmd.mod_step) begin
          cnt_r <= cnt_r - MOD_CNT_W'(1);
          plo_r <= (KEY_W + RECIP_LO_W)'(key_r) * (KEY_W + RECIP_LO_W)'(RECIP_LO);
          phi_r <= (KEY_W + RECIP_HI_W)'(key_r) * (KEY_W + RECIP_HI_W)'(RECIP_HI);
          qlo_r <= prod[RECIP_SH +: BKT_W];
        end
      end
    end
  endgenerate

  always_comb begin
    if (cmd.load) begin
      bkt_nxt = bkt_load;
    end else if (cmd.mod_step && mod_last) begin
      bkt_nxt = bkt_mod;
    end else if (advance) begin
      bkt_nxt = bkt_inc;
    end else begin
      bkt_nxt = bkt_r;
    end
  end

  always_comb begin
    res_status = ST_MISSING;
    res_sub    = '0;
    res_bkt    = '0;
    if (type_r == REQ_INSERT) begin
      if (!face_ok) begin
        res_status = ST_BAD_FACE;
      end else if (slot_free) begin
        res_status = ST_INSERTED;
        res_sub    = HSUB_W'(sub_r);
        res_bkt    = HBKT_W'(bkt_r);
      end else begin
        res_status = ST_FULL;
      end
    end else if (hit) begin
      res_status = ST_FOUND;
      res_sub    = HSUB_W'(cmp_sub_r);
      res_bkt    = HBKT_W'(cmp_bkt_r);
    end
  end

  assign sts.is_search = (type_r == REQ_SEARCH);
  assign sts.mod_last  = mod_last;
  assign sts.ins_done  = !face_ok || slot_free || sub_last;
  assign sts.srch_done = cmp_pend_r && (hit || cmp_last_r);

  dlht_ram #(
    .WIDTH(WORD_W),
    .DEPTH(SLOT_TOTAL)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ins_write),
    .waddr(slot_addr),
    .wdata({face_bits, exp_r, key_r}),
    .re   (cmd.srch_step),
    .raddr(slot_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      cmp_pend_r <= 1'b0;
    end else begin
      if (ins_write) begin
        occ_r[slot_addr] <= 1'b1;
      end
      if (cmd.load) begin
        cmp_pend_r <= 1'b0;
      end else if (cmd.srch_step) begin
        cmp_pend_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bkt_r <= bkt_nxt;
    if (cmd.load) begin
      type_r <= in_type;
      key_r  <= in_key;
      exp_r  <= in_exp;
      face_r <= in_face;
      sub_r  <= '0;
      kcnt_r <= in_key;
    end else if (advance) begin
      sub_r  <= sub_r + SUB_W'(1);
      kcnt_r <= kcnt_inc;
    end
    if (cmd.srch_step) begin
      cmp_occ_r  <= occ_r[slot_addr];
      cmp_sub_r  <= sub_r;
      cmp_bkt_r  <= bkt_r;
      cmp_last_r <= sub_last;
    end
    if (cmd.res_load) begin
      res_status_r <= res_status;
      res_sub_r    <= res_sub;
      res_bkt_r    <= res_bkt;
    end
  end

  assign out_status = res_status_r;
  assign out_sub    = res_sub_r;
  assign out_bkt    = res_bkt_r;
endmodule

// ===== rtl/dleft_hash_table_insert_search.sv =====
// Top level of the d-left hash table: insert and search by fingerprint.
// Usage:
//   in_req carries one request per valid/ready handshake: req_type (insert or
//   search), key_fingerprint, expire_time and face_number.
//   out_res returns exactly one result per request: status, hit_subtable and
//   hit_bucket, in request order.
//   A request probes one subtable per cycle through the slot RAM, unless a
//   stalled result holds probing. Insert: an accept state, then probes until
//   a free slot is found or the last subtable is probed; a bad face finishes
//   on the first probe. Search: an accept state, then probes whose registered
//   RAM read puts each compare one register behind its probe.
//   When BUCKETS is not a power of two, the base bucket is reduced by a
//   reciprocal multiply in the S_MOD state before the first probe.
//   One request is in flight at a time; the next one is accepted as soon as the
//   result is registered, even while that result still waits on out_res.
//   When out_res stalls with a result pending, probing of the next request
//   holds until the result is taken.
//   Reset (synchronous, active low) marks every bucket free by clearing the
//   occupancy bits; stale slot RAM words are ignored, so no clearing pass is needed.
`timescale 1ns / 1ps
module dleft_hash_table_insert_search (
  input  logic        clk,
  input  logic        rst_n,
  dlht_req_if.sink    in_req,
  dlht_res_if.source  out_res
);
  import dlht_pkg::*;

  dlht_cmd_t cmd;
  dlht_sts_t sts;

  dlht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_type  (in_req.req_type),
    .in_ready (in_req.ready),
    .out_valid(out_res.valid),
    .out_ready(out_res.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dlht_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_type   (in_req.req_type),
    .in_key    (in_req.key_fingerprint),
    .in_exp    (in_req.expire_time),
    .in_face   (in_req.face_number),
    .out_status(out_res.status),
    .out_sub   (out_res.hit_subtable),
    .out_bkt   (out_res.hit_bucket)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request accepted while previous request still in flight");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !out_res.valid || out_res.ready)
    else $error("result register overwritten before it was taken");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_res.valid)
    else $error("finished request did not produce a result");

  a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && (out_res.status == ST_BAD_FACE || out_res.status == ST_FULL ||
                      out_res.status == ST_MISSING)
    |-> out_res.hit_subtable == '0 && out_res.hit_bucket == '0)
    else $error("error or miss result carries a nonzero location");
endmodule
